// ===== hdl/pitt_pkg.sv =====
// types, widths and arithmetic helpers shared by the point-in-tetrahedron test
`default_nettype none

package pitt_pkg;

    localparam int COORD_WIDTH = 16;

    // coordinate difference, exact
    localparam int DIFF_W  = COORD_WIDTH + 1;
    // vertex sum and scaled centroid offset 4*p - s
    localparam int SUM_W   = COORD_WIDTH + 3;
    // face normal component (cross product of face edges)
    localparam int CROSS_W = 2 * DIFF_W;
    // one term of a dot product
    localparam int PROD_W  = DIFF_W + CROSS_W;
    // full orientation determinant
    localparam int DET_W   = PROD_W + 1;
    // one squared offset component, never negative
    localparam int SQ_W    = 2 * SUM_W - 2;
    // squared distance scaled by sixteen
    localparam int DIST_W  = 2 * SUM_W;

    localparam int CFG_DATA_W  = 3 * COORD_WIDTH;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_B = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_C = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_D = CFG_INDEX_W'(3);

    typedef logic signed [COORD_WIDTH-1:0]   coord_t;
    typedef logic [2:0][COORD_WIDTH-1:0]     point_t;
    typedef logic [3:0][2:0][COORD_WIDTH-1:0] vtx_set_t;
    typedef logic [2:0][DIFF_W-1:0]          diff_vec_t;
    typedef logic [2:0][SUM_W-1:0]           sum_vec_t;
    typedef logic [2:0][CROSS_W-1:0]         cross_vec_t;
    typedef logic [2:0][PROD_W-1:0]          prod_vec_t;
    typedef logic [2:0][SQ_W-1:0]            sq_vec_t;

    // values that depend on the tetrahedron only
    typedef struct packed {
        sum_vec_t         sum4;
        cross_vec_t [3:0] normal;
        logic [DIST_W-1:0] radius_sq;
        logic             det0_pos;
        logic             det0_neg;
    } tet_coef_t;

    // p - r per component
    function automatic diff_vec_t vec_diff(input point_t p, input point_t r);
        diff_vec_t d;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = DIFF_W'($signed(p[k])) - DIFF_W'($signed(r[k]));
        end
        return d;
    endfunction

    // 4*p - s per component
    function automatic sum_vec_t vec_offset4(input point_t p, input sum_vec_t s);
        sum_vec_t t;
        for (int k = 0; k < 3; k++)
        begin
            t[k] = (SUM_W'($signed(p[k])) <<< 2) - $signed(s[k]);
        end
        return t;
    endfunction

    // u x v
    function automatic cross_vec_t vec_cross(input diff_vec_t u, input diff_vec_t v);
        logic signed [CROSS_W-1:0] ux, uy, uz, vx, vy, vz;
        cross_vec_t n;
        ux   = CROSS_W'($signed(u[0]));
        uy   = CROSS_W'($signed(u[1]));
        uz   = CROSS_W'($signed(u[2]));
        vx   = CROSS_W'($signed(v[0]));
        vy   = CROSS_W'($signed(v[1]));
        vz   = CROSS_W'($signed(v[2]));
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        return n;
    endfunction

    // component products of a dot product
    function automatic prod_vec_t vec_scale(input diff_vec_t d, input cross_vec_t n);
        prod_vec_t p;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = PROD_W'($signed(d[k])) * PROD_W'($signed(n[k]));
        end
        return p;
    endfunction

    function automatic logic [DET_W-1:0] det_sum(input prod_vec_t p);
        return DET_W'($signed(p[0])) + DET_W'($signed(p[1])) + DET_W'($signed(p[2]));
    endfunction

    // squares fit exactly, |t| stays below 2^(SUM_W-1)
    function automatic sq_vec_t vec_square(input sum_vec_t t);
        logic signed [SQ_W-1:0] e;
        sq_vec_t q;
        for (int k = 0; k < 3; k++)
        begin
            e    = SQ_W'($signed(t[k]));
            q[k] = e * e;
        end
        return q;
    endfunction

    function automatic logic [DIST_W-1:0] dist_sum(input sq_vec_t q);
        return DIST_W'(q[0]) + DIST_W'(q[1]) + DIST_W'(q[2]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pitt_tet_prep.sv =====
// tetrahedron coefficient pipeline: vertex sum, face normals, sphere radius, base orientation
`default_nettype none

module pitt_tet_prep (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pitt_pkg::vtx_set_t  vtx,
    output pitt_pkg::tet_coef_t      coef
);
    import pitt_pkg::*;

    // stage 1: edges, vertex sum, vertex offsets
    diff_vec_t         edge_cb_reg, edge_db_reg, edge_ab_reg;
    diff_vec_t         edge_ca_reg, edge_da_reg, edge_ba_reg;
    diff_vec_t         edge_cb_next, edge_db_next, edge_ab_next;
    diff_vec_t         edge_ca_next, edge_da_next, edge_ba_next;
    sum_vec_t          sum4_reg, sum4_next;
    sum_vec_t          offset_reg [4];
    sum_vec_t          offset_next [4];
    // stage 2: normals, squared offsets
    cross_vec_t        normal_reg [4];
    cross_vec_t        normal_next [4];
    sq_vec_t           vtx_sq_reg [4];
    sq_vec_t           vtx_sq_next [4];
    diff_vec_t         base_edge_reg;
    // stage 3: base orientation terms, vertex distances
    prod_vec_t         det0_prod_reg, det0_prod_next;
    logic [DIST_W-1:0] vtx_dist_reg [4];
    logic [DIST_W-1:0] vtx_dist_next [4];
    // stage 4: radius and base sign
    logic [DIST_W-1:0] radius_sq_reg, radius_sq_next;
    logic              det0_pos_reg, det0_pos_next;
    logic              det0_neg_reg, det0_neg_next;

    logic [DIST_W-1:0] max01, max23;
    logic [DET_W-1:0]  det0;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum4_next[k] = SUM_W'($signed(vtx[0][k])) + SUM_W'($signed(vtx[1][k]))
                         + SUM_W'($signed(vtx[2][k])) + SUM_W'($signed(vtx[3][k]));
        end
        for (int i = 0; i < 4; i++)
        begin
            offset_next[i] = vec_offset4(vtx[i], sum4_next);
            vtx_sq_next[i] = vec_square(offset_reg[i]);
            vtx_dist_next[i] = dist_sum(vtx_sq_reg[i]);
        end
        edge_cb_next = vec_diff(vtx[2], vtx[1]);
        edge_db_next = vec_diff(vtx[3], vtx[1]);
        edge_ab_next = vec_diff(vtx[0], vtx[1]);
        edge_ca_next = vec_diff(vtx[2], vtx[0]);
        edge_da_next = vec_diff(vtx[3], vtx[0]);
        edge_ba_next = vec_diff(vtx[1], vtx[0]);

        // normal of the face opposite each vertex, oriented so that
        // n_i . (p - base) is the orientation with p in place of vertex i
        normal_next[0] = vec_cross(edge_db_reg, edge_cb_reg);
        normal_next[1] = vec_cross(edge_ca_reg, edge_da_reg);
        normal_next[2] = vec_cross(edge_ab_reg, edge_db_reg);
        normal_next[3] = vec_cross(edge_cb_reg, edge_ab_reg);

        det0_prod_next = vec_scale(base_edge_reg, normal_reg[1]);

        det0          = det_sum(det0_prod_reg);
        det0_neg_next = det0[DET_W-1];
        det0_pos_next = !det0[DET_W-1] && (|det0);

        max01          = (vtx_dist_reg[0] > vtx_dist_reg[1]) ? vtx_dist_reg[0] : vtx_dist_reg[1];
        max23          = (vtx_dist_reg[2] > vtx_dist_reg[3]) ? vtx_dist_reg[2] : vtx_dist_reg[3];
        radius_sq_next = (max01 > max23) ? max01 : max23;
    end

    // cleared at reset, matching the all-zero vertex set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cb_reg   <= '0;
            edge_db_reg   <= '0;
            edge_ab_reg   <= '0;
            edge_ca_reg   <= '0;
            edge_da_reg   <= '0;
            edge_ba_reg   <= '0;
            sum4_reg      <= '0;
            base_edge_reg <= '0;
            det0_prod_reg <= '0;
            radius_sq_reg <= '0;
            det0_pos_reg  <= 1'b0;
            det0_neg_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                offset_reg[i]   <= '0;
                normal_reg[i]   <= '0;
                vtx_sq_reg[i]   <= '0;
                vtx_dist_reg[i] <= '0;
            end
        end
        else
        begin
            edge_cb_reg   <= edge_cb_next;
            edge_db_reg   <= edge_db_next;
            edge_ab_reg   <= edge_ab_next;
            edge_ca_reg   <= edge_ca_next;
            edge_da_reg   <= edge_da_next;
            edge_ba_reg   <= edge_ba_next;
            sum4_reg      <= sum4_next;
            base_edge_reg <= edge_ba_reg;
            det0_prod_reg <= det0_prod_next;
            radius_sq_reg <= radius_sq_next;
            det0_pos_reg  <= det0_pos_next;
            det0_neg_reg  <= det0_neg_next;
            for (int i = 0; i < 4; i++)
            begin
                offset_reg[i]   <= offset_next[i];
                normal_reg[i]   <= normal_next[i];
                vtx_sq_reg[i]   <= vtx_sq_next[i];
                vtx_dist_reg[i] <= vtx_dist_next[i];
            end
        end
    end

    always_comb
    begin
        coef.sum4      = sum4_reg;
        coef.radius_sq = radius_sq_reg;
        coef.det0_pos  = det0_pos_reg;
        coef.det0_neg  = det0_neg_reg;
        for (int i = 0; i < 4; i++)
        begin
            coef.normal[i] = normal_reg[i];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/point_in_tetrahedron_test_unit.sv =====
// point-in-tetrahedron test: configuration registers, query pipeline and output register
//
// usage
//   the four vertices are written through cfg_we / cfg_index / cfg_data, one
//   vertex per register, x in the low bits; writes to other indexes are dropped.
//   write only while no query is in flight; the coefficient pipeline settles
//   stage by stage, and the query pipeline covers that, so a query may follow the
//   last write in the next cycle
//   query points arrive on in_valid / in_stall, a transfer happens when valid
//   is high and stall is low; results leave on out_valid / out_stall
//   inside_res is 1 only when the point lies within the bounding sphere and
//   all five orientation determinants share one non-zero sign
// timing
//   five register stages: point, offsets, products, signs and output, passed
//   in that order; one query per cycle sustained while out_stall is low,
//   set by the fully pipelined multiplier stage
// reset
//   clears the vertices to zero, a degenerate tetrahedron, so every query
//   answers outside until vertices are written; the pipeline is emptied
// stall
//   a held result freezes only the full stages in an unbroken run behind it; empty
//   stages keep filling, so queries are still taken until the pipeline is full
`default_nettype none

module point_in_tetrahedron_test_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pitt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pitt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire pitt_pkg::coord_t                    point_x,
    input  wire pitt_pkg::coord_t                    point_y,
    input  wire pitt_pkg::coord_t                    point_z,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     inside_res
);
    import pitt_pkg::*;

    localparam int NUM_STAGES = 5;

    // vertex registers
    vtx_set_t          vtx_reg, vtx_next;
    tet_coef_t         coef;

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_load;

    // stage 1: query point
    point_t            point_reg, point_next;
    // stage 2: offsets from vertex a, vertex b and the centroid
    diff_vec_t         diff_a_reg, diff_a_next;
    diff_vec_t         diff_b_reg, diff_b_next;
    sum_vec_t          offset_reg, offset_next;
    // stage 3: determinant terms and squared offsets
    prod_vec_t         slot_prod_reg [4];
    prod_vec_t         slot_prod_next [4];
    sq_vec_t           sq_reg, sq_next;
    // stage 4: signs of the four substituted determinants and the distance
    logic [3:0]        det_pos_reg, det_pos_next;
    logic [3:0]        det_neg_reg, det_neg_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    // stage 5: output register
    logic              inside_reg, inside_next;

    logic [DET_W-1:0]  slot_det [4];

    // configuration writes
    always_comb
    begin
        vtx_next = vtx_reg;
        case (cfg_index)
            REG_VERTEX_A: vtx_next[0] = cfg_data;
            REG_VERTEX_B: vtx_next[1] = cfg_data;
            REG_VERTEX_C: vtx_next[2] = cfg_data;
            REG_VERTEX_D: vtx_next[3] = cfg_data;
            default:      vtx_next    = vtx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg <= '0;
        end
        else if (cfg_we)
        begin
            vtx_reg <= vtx_next;
        end
    end

    // sphere radius, face normals and base orientation from the vertices
    pitt_tet_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx_reg),
        .coef  (coef)
    );

    // a stage loads when empty or when its item moves on; bubbles close up
    always_comb
    begin
        stage_load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_load[k] = !valid_reg[k] || stage_load[k+1];
        end
        valid_next[0] = stage_load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !stage_load[0];
    assign out_valid  = valid_reg[NUM_STAGES-1];
    assign inside_res = inside_reg;

    // datapath
    always_comb
    begin
        point_next = {point_z, point_y, point_x};

        diff_a_next = vec_diff(point_reg, vtx_reg[0]);
        diff_b_next = vec_diff(point_reg, vtx_reg[1]);
        offset_next = vec_offset4(point_reg, coef.sum4);

        // point in place of vertex a, b, c, d in turn
        slot_prod_next[0] = vec_scale(diff_b_reg, coef.normal[0]);
        slot_prod_next[1] = vec_scale(diff_a_reg, coef.normal[1]);
        slot_prod_next[2] = vec_scale(diff_b_reg, coef.normal[2]);
        slot_prod_next[3] = vec_scale(diff_b_reg, coef.normal[3]);
        sq_next           = vec_square(offset_reg);

        for (int i = 0; i < 4; i++)
        begin
            slot_det[i]     = det_sum(slot_prod_reg[i]);
            det_neg_next[i] = slot_det[i][DET_W-1];
            det_pos_next[i] = !slot_det[i][DET_W-1] && (|slot_det[i]);
        end
        dist_next = dist_sum(sq_reg);

        // strictly inside the sphere, and every sign equal to the base sign
        inside_next = (dist_reg < coef.radius_sq)
                   && (((&det_pos_reg) && coef.det0_pos) || ((&det_neg_reg) && coef.det0_neg));
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            point_reg <= point_next;
        end
        if (stage_load[1])
        begin
            diff_a_reg <= diff_a_next;
            diff_b_reg <= diff_b_next;
            offset_reg <= offset_next;
        end
        if (stage_load[2])
        begin
            for (int i = 0; i < 4; i++)
            begin
                slot_prod_reg[i] <= slot_prod_next[i];
            end
            sq_reg <= sq_next;
        end
        if (stage_load[3])
        begin
            det_pos_reg <= det_pos_next;
            det_neg_reg <= det_neg_next;
            dist_reg    <= dist_next;
        end
        if (stage_load[4])
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/pitt_inside_checker.sv =====
// checker for the point-in-tetrahedron test unit: tracks the vertices, predicts and compares
`timescale 1ns / 100ps
`default_nettype none

module pitt_inside_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pitt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pitt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire pitt_pkg::coord_t                 point_x,
    input  wire pitt_pkg::coord_t                 point_y,
    input  wire pitt_pkg::coord_t                 point_z,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic                             inside_res,
    output int                                    pending,
    output int                                    fail_count
);
    import pitt_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // wide enough for every determinant and scaled distance without overflow
    typedef logic signed [63:0] wide_t;
    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } pos_t;

    // one query in flight with its predicted answer
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   hit;
    } query_t;

    pos_t   corner [4];
    query_t query_q [$];
    query_t oldest;
    query_t fresh;
    int     error_total;

    function automatic pos_t make_pos(input coord_t x, input coord_t y, input coord_t z);
        pos_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic pos_t pos_sub(input pos_t p, input pos_t r);
        pos_t d;
        d.x = p.x - r.x;
        d.y = p.y - r.y;
        d.z = p.z - r.z;
        return d;
    endfunction

    // sign of det[b-a; c-a; d-a]
    function automatic int orientation(input pos_t a, input pos_t b, input pos_t c,
                                       input pos_t d);
        pos_t  u, v, w;
        wide_t nx, ny, nz, det;
        u   = pos_sub(b, a);
        v   = pos_sub(c, a);
        w   = pos_sub(d, a);
        nx  = v.y * w.z - v.z * w.y;
        ny  = v.z * w.x - v.x * w.z;
        nz  = v.x * w.y - v.y * w.x;
        det = u.x * nx + u.y * ny + u.z * nz;
        return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
    endfunction

    // squared length of 4*p - s
    function automatic wide_t offset_sq(input pos_t p, input pos_t s);
        wide_t tx, ty, tz;
        tx = 4 * p.x - s.x;
        ty = 4 * p.y - s.y;
        tz = 4 * p.z - s.z;
        return tx * tx + ty * ty + tz * tz;
    endfunction

    function automatic logic predict_inside(input pos_t q);
        pos_t  s;
        wide_t radius_sq, dq;
        int    sg;
        logic  hit;
        s.x = corner[0].x + corner[1].x + corner[2].x + corner[3].x;
        s.y = corner[0].y + corner[1].y + corner[2].y + corner[3].y;
        s.z = corner[0].z + corner[1].z + corner[2].z + corner[3].z;
        radius_sq = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (offset_sq(corner[i], s) > radius_sq)
                radius_sq = offset_sq(corner[i], s);
        end
        dq  = offset_sq(q, s);
        hit = 1'b0;
        // strictly inside the sphere, then all five signs equal and non-zero
        if (dq < radius_sq)
        begin
            sg  = orientation(corner[0], corner[1], corner[2], corner[3]);
            hit = (sg != 0)
               && (orientation(q, corner[1], corner[2], corner[3]) == sg)
               && (orientation(corner[0], q, corner[2], corner[3]) == sg)
               && (orientation(corner[0], corner[1], q, corner[3]) == sg)
               && (orientation(corner[0], corner[1], corner[2], q) == sg);
        end
        return hit;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                corner[i] = '0;
            query_q.delete();
            error_total = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C, REG_VERTEX_D:
                        corner[cfg_index[1:0]] = make_pos(cfg_data[COORD_WIDTH-1:0],
                                                     cfg_data[2*COORD_WIDTH-1:COORD_WIDTH],
                                                     cfg_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
                    default:
                        ;
                endcase
            end
            // results first, so a result never meets the query taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (query_q.size() == 0)
                begin
                    error_total++;
                    if (error_total <= REPORT_LIMIT)
                        $display("%0t: inside_res %0b arrived with no query in flight",
                                 $time, inside_res);
                end
                else
                begin
                    oldest = query_q.pop_front();
                    if (inside_res !== oldest.hit)
                    begin
                        error_total++;
                        if (error_total <= REPORT_LIMIT)
                            $display("%0t: point (%0d, %0d, %0d) inside_res expected %0b got %0b",
                                     $time, oldest.x, oldest.y, oldest.z, oldest.hit,
                                     inside_res);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh.x   = point_x;
                fresh.y   = point_y;
                fresh.z   = point_z;
                fresh.hit = predict_inside(make_pos(point_x, point_y, point_z));
                query_q.insert(query_q.size(), fresh);
            end
        end
        pending    <= query_q.size();
        fail_count <= error_total;
    end

endmodule

`default_nettype wire

// ===== tb/tb_point_in_tetrahedron_test_unit.sv =====
// testbench top for the point-in-tetrahedron test unit: stimulus, flow control and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_point_in_tetrahedron_test_unit;
    import pitt_pkg::*;

    localparam int COORD_MIN     = -(1 << (COORD_WIDTH - 1));
    localparam int COORD_MAX     = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 110;
    // long receiver hold-off, started once enough transfers have gone in
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int SETTLE_CYCLES = 20;

    // kinds of tetrahedron for the random phases
    typedef enum int {
        SHAPE_COINCIDENT,
        SHAPE_COPLANAR,
        SHAPE_SMALL,
        SHAPE_MEDIUM,
        SHAPE_FULL
    } shape_e;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    logic                   out_valid;
    logic                   out_stall;
    logic                   inside_res;

    int pending;
    int fail_count;

    // current vertices, kept here only to steer the stimulus
    int tet_x [4];
    int tet_y [4];
    int tet_z [4];

    int     burst_left = 0;
    int     sent_count = 0;
    int     cycle_count = 0;
    logic   long_hold_done = 1'b0;
    int     qx, qy, qz, pick, k;
    shape_e shape;

    always #5 clk = ~clk;

    point_in_tetrahedron_test_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    pitt_inside_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_point_in_tetrahedron_test_unit NOT OK");
            $finish;
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // any value of the full coordinate range
    function automatic int rand_coord();
        coord_t c;
        c = coord_t'($urandom);
        return int'(c);
    endfunction

    // random offset of up to span either side, kept in range
    function automatic int spread(input int c, input int span);
        return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // centre far enough from the range ends for a cluster of the given span
    function automatic int pick_centre(input int span);
        return int'($urandom_range(0, COORD_MAX - COORD_MIN - 2 * span)) + COORD_MIN + span;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_corner(input int i);
        return {COORD_WIDTH'(tet_z[i]), COORD_WIDTH'(tet_y[i]), COORD_WIDTH'(tet_x[i])};
    endfunction

    // one register write per edge; the caller lowers cfg_we after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // stop offering queries and wait until every answer is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // load tet_* into the vertex registers, optionally with a write to an unused index
    task automatic load_tetra(input logic stray);
        wait_for_drain();
        write_reg(REG_VERTEX_A, pack_corner(0));
        write_reg(REG_VERTEX_B, pack_corner(1));
        write_reg(REG_VERTEX_C, pack_corner(2));
        write_reg(REG_VERTEX_D, pack_corner(3));
        if (stray)
            write_reg(CFG_INDEX_W'($urandom_range(int'(REG_VERTEX_D) + 1,
                                                   (1 << CFG_INDEX_W) - 1)),
                      CFG_DATA_W'({$urandom, $urandom}));
        cfg_we <= 1'b0;
    endtask

    task automatic set_corner(input int i, input int x, input int y, input int z);
        tet_x[i] = x;
        tet_y[i] = y;
        tet_z[i] = z;
    endtask

    // one query transfer; the sender idles between bursts of random length
    task automatic send_point(input int x, input int y, input int z);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        point_x  <= COORD_WIDTH'(x);
        point_y  <= COORD_WIDTH'(y);
        point_z  <= COORD_WIDTH'(z);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // weighted mix of the vertices; zeroed weights push the point onto or near a face or edge
    task automatic blend_point(input int zeros, output int x, output int y, output int z);
        int     w [4];
        longint wsum, sx, sy, sz;
        for (int i = 0; i < 4; i++)
            w[i] = $urandom_range(1, 255);
        for (int i = 0; i < zeros; i++)
            w[$urandom_range(0, 3)] = 0;
        wsum = 0;
        sx   = 0;
        sy   = 0;
        sz   = 0;
        for (int i = 0; i < 4; i++)
        begin
            wsum += w[i];
            sx   += longint'(w[i]) * tet_x[i];
            sy   += longint'(w[i]) * tet_y[i];
            sz   += longint'(w[i]) * tet_z[i];
        end
        x = int'(sx / wsum);
        y = int'(sy / wsum);
        z = int'(sz / wsum);
    endtask

    task automatic pick_tetra(input shape_e kind);
        int span, cx, cy, cz;
        span = (kind == SHAPE_SMALL) ? 30 : 3000;
        cx   = pick_centre(span);
        cy   = pick_centre(span);
        cz   = pick_centre(span);
        for (int i = 0; i < 4; i++)
        begin
            case (kind)
                SHAPE_FULL:
                    set_corner(i, rand_coord(), rand_coord(), rand_coord());
                SHAPE_COINCIDENT:
                    set_corner(i, cx, cy, cz);
                SHAPE_COPLANAR:
                    set_corner(i, spread(cx, span), spread(cy, span), cz);
                default:
                    set_corner(i, spread(cx, span), spread(cy, span), spread(cz, span));
            endcase
        end
    endtask

    // receiver: stall pattern changes every so often, plus one long hold-off
    // that lets the pipeline fill and push back on the sender
    initial
    begin : receiver
        int mode, run;
        out_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(20, 200);
            repeat (run)
            begin
                @(posedge clk);
                if (!long_hold_done && sent_count >= HOLD_AFTER)
                begin
                    long_hold_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 6);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_VERTEX_A;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        point_x   <= '0;
        point_y   <= '0;
        point_z   <= '0;
        for (int i = 0; i < 4; i++)
            set_corner(i, 0, 0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight after reset all vertices sit at the origin: always outside
        send_point(0, 0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1, -1, 1);

        // corner tetrahedron with even vertex sums, so sphere and face cases land exactly
        set_corner(0, 0, 0, 0);
        set_corner(1, 100, 0, 0);
        set_corner(2, 0, 100, 0);
        set_corner(3, 0, 0, 100);
        load_tetra(1'b1);
        send_point(25, 25, 25);       // centroid
        send_point(10, 10, 10);
        send_point(1, 1, 1);          // just inside a vertex
        send_point(33, 33, 33);       // just inside the slanted face
        send_point(0, 0, 0);          // on a vertex
        send_point(50, 0, 0);         // on an edge
        send_point(30, 30, 0);        // on a face
        send_point(33, 33, 34);       // on the slanted face
        send_point(-50, 50, 50);      // exactly on the bounding sphere
        send_point(-1, 10, 10);       // just outside a face
        send_point(COORD_MAX, COORD_MIN, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);

        // every register all ones: four coincident vertices
        for (int i = 0; i < 4; i++)
            set_corner(i, -1, -1, -1);
        load_tetra(1'b0);
        send_point(-1, -1, -1);
        send_point(0, 0, 0);

        // tetrahedron spanning the whole coordinate range
        set_corner(0, COORD_MIN, COORD_MIN, COORD_MIN);
        set_corner(1, COORD_MAX, COORD_MIN, COORD_MIN);
        set_corner(2, COORD_MIN, COORD_MAX, COORD_MIN);
        set_corner(3, COORD_MIN, COORD_MIN, COORD_MAX);
        load_tetra(1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1);
        send_point(COORD_MIN / 2, COORD_MIN / 2, COORD_MIN / 2);
        send_point(0, 0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);

        // random tetrahedra, most queries aimed in and around them
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 1)
                shape = SHAPE_COPLANAR;
            else if (ph == 2)
                shape = SHAPE_COINCIDENT;
            else
                shape = shape_e'($urandom_range(int'(SHAPE_SMALL), int'(SHAPE_FULL)));
            pick_tetra(shape);
            load_tetra(logic'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                k    = $urandom_range(0, 3);
                if (pick < 55)
                    blend_point(0, qx, qy, qz);
                else if (pick < 65)
                    blend_point($urandom_range(1, 2), qx, qy, qz);
                else if (pick < 70)
                begin
                    qx = tet_x[k];
                    qy = tet_y[k];
                    qz = tet_z[k];
                end
                else if (pick < 80)
                begin
                    qx = spread(tet_x[k], 3);
                    qy = spread(tet_y[k], 3);
                    qz = spread(tet_z[k], 3);
                end
                else
                begin
                    qx = rand_coord();
                    qy = rand_coord();
                    qz = rand_coord();
                end
                send_point(qx, qy, qz);
            end
        end

        // let the last answers out, then a short quiet spell for anything stray
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_point_in_tetrahedron_test_unit OK");
        else
            $display("tb_point_in_tetrahedron_test_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== point_in_tetrahedron_test_unit.f =====
hdl/pitt_pkg.sv
hdl/pitt_tet_prep.sv
hdl/point_in_tetrahedron_test_unit.sv
tb/pitt_inside_checker.sv
tb/tb_point_in_tetrahedron_test_unit.sv
